// File: rtl/pwcb_pkg.sv
`default_nettype none

package pwcb_pkg;

    // buffer geometry
    localparam int BUFFER_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;

    // field widths
    localparam int KIND_W  = 2;
    localparam int TIME_W  = 32;
    localparam int PULSE_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_ARM  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EDGE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POLL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FSK_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES = 2'd3;

    // register reset values
    localparam logic [PULSE_W-1:0] MIN_PULSE_RST   = 16'd100;
    localparam logic [TIME_W-1:0]  GAP_LIMIT_RST   = 32'd100000;
    localparam logic [CNT_W-1:0]   MIN_SAMPLES_RST = CNT_W'(30);

    // classified item as it waits between front and back
    typedef struct packed {
        logic              is_arm;
        logic              is_edge;
        logic              is_poll;
        logic              is_read;
        logic [TIME_W-1:0] timestamp;
        logic              line_level;
        logic [ADDR_W-1:0] read_index;
    } t_item;

endpackage

`default_nettype wire

// File: rtl/pwcb_front.sv
`default_nettype none

module pwcb_front
    import pwcb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [TIME_W-1:0] i_timestamp,
    input  wire logic              i_line_level,
    input  wire logic [ADDR_W-1:0] i_read_index,
    output logic                   o_q_valid,
    output t_item                  o_q_item,
    input  wire logic              i_q_pop
);

    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    t_item      r_q [2];
    t_item      w_item;
    logic       w_push;

    // decode the kind into one flag per operation
    always_comb begin
        w_item            = '0;
        w_item.timestamp  = i_timestamp;
        w_item.line_level = i_line_level;
        w_item.read_index = i_read_index;
        unique case (i_kind)
            KIND_ARM:  w_item.is_arm  = 1'b1;
            KIND_EDGE: w_item.is_edge = 1'b1;
            KIND_POLL: w_item.is_poll = 1'b1;
            KIND_READ: w_item.is_read = 1'b1;
            default:   w_item.is_read = 1'b1;
        endcase
    end

    // two-entry queue toward the back end
    assign o_in_stall = (r_count == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !i_q_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_q_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pwcb_back.sv
`default_nettype none

module pwcb_back
    import pwcb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_q_valid,
    input  wire t_item                 i_q_item,
    output logic                       o_q_pop,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_capture_done,
    output logic [CNT_W-1:0]           o_sample_count,
    output logic                       o_capturing,
    output logic [TIME_W-1:0]          o_read_value,
    output logic                       o_read_valid
);

    // configuration registers
    logic               r_fsk_mode;
    logic [PULSE_W-1:0] r_min_pulse;
    logic [TIME_W-1:0]  r_gap_limit;
    logic [CNT_W-1:0]   r_min_samples;

    // capture state
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [TIME_W-1:0] r_last_time;
    logic [TIME_W-1:0] n_last_time;
    logic              r_enabled;
    logic              n_enabled;

    // sample memory and its registered read port
    logic [TIME_W-1:0] r_mem [BUFFER_DEPTH];
    logic [TIME_W-1:0] r_rd_data;

    // output register
    logic              r_out_valid;
    logic              r_out_done;
    logic [CNT_W-1:0]  r_out_count;
    logic              r_out_enabled;
    logic              r_out_rd_hit;

    logic              w_issue;
    logic [TIME_W-1:0] w_span;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic              w_done;
    logic              w_rd_hit;

    assign w_issue = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop = w_issue;
    assign w_span  = i_q_item.timestamp - r_last_time;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsk_mode    <= 1'b0;
            r_min_pulse   <= MIN_PULSE_RST;
            r_gap_limit   <= GAP_LIMIT_RST;
            r_min_samples <= MIN_SAMPLES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FSK_MODE:    r_fsk_mode    <= i_cfg_data[0];
                CFG_MIN_PULSE:   r_min_pulse   <= i_cfg_data[PULSE_W-1:0];
                CFG_GAP_LIMIT:   r_gap_limit   <= i_cfg_data[TIME_W-1:0];
                CFG_MIN_SAMPLES: r_min_samples <= i_cfg_data[CNT_W-1:0];
                default:         r_fsk_mode    <= r_fsk_mode;
            endcase
        end
    end

    // per-item state update
    always_comb begin
        logic [CNT_W-1:0] cnt_gap;
        logic [CNT_W-1:0] cnt_wr;
        cnt_gap     = '0;
        cnt_wr      = '0;
        n_count     = r_count;
        n_last_time = r_last_time;
        n_enabled   = r_enabled;
        w_wr_en     = 1'b0;
        w_wr_addr   = '0;
        w_done      = 1'b0;
        w_rd_hit    = 1'b0;
        if (i_q_item.is_arm) begin
            n_count   = '0;
            n_enabled = 1'b1;
        end else if (i_q_item.is_edge) begin
            if (r_enabled) begin
                // long gap restarts the frame
                cnt_gap = (w_span > r_gap_limit) ? '0 : r_count;
                cnt_wr  = cnt_gap;
                if (w_span >= TIME_W'(r_min_pulse) &&
                    cnt_gap < CNT_W'(BUFFER_DEPTH)) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = cnt_gap[ADDR_W-1:0];
                    cnt_wr    = cnt_gap + CNT_W'(1);
                end
                n_count = cnt_wr;
                // full buffer leaves the reference time alone
                if (cnt_wr < CNT_W'(BUFFER_DEPTH)) begin
                    if (r_fsk_mode && cnt_wr == CNT_W'(1) && !i_q_item.line_level) begin
                        n_count = '0;
                    end
                    n_last_time = i_q_item.timestamp;
                end
            end
        end else if (i_q_item.is_poll) begin
            if (r_count >= r_min_samples && w_span > r_gap_limit) begin
                n_enabled = 1'b0;
                w_done    = 1'b1;
            end
        end else begin
            w_rd_hit = ({1'b0, i_q_item.read_index} < r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_last_time <= '0;
            r_enabled   <= 1'b0;
        end else if (w_issue) begin
            r_count     <= n_count;
            r_last_time <= n_last_time;
            r_enabled   <= n_enabled;
        end
    end

    // sample memory write
    always_ff @(posedge i_clk) begin
        if (w_issue && w_wr_en) begin
            r_mem[w_wr_addr] <= w_span;
        end
    end

    // sample memory read, held while the result waits
    always_ff @(posedge i_clk) begin
        if (w_issue && i_q_item.is_read) begin
            r_rd_data <= r_mem[i_q_item.read_index];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_issue) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_out_done    <= w_done;
            r_out_count   <= n_count;
            r_out_enabled <= n_enabled;
            r_out_rd_hit  <= w_rd_hit;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_capture_done = r_out_done;
    assign o_sample_count = r_out_count;
    assign o_capturing    = r_out_enabled;
    assign o_read_valid   = r_out_rd_hit;
    assign o_read_value   = r_out_rd_hit ? r_rd_data : '0;

endmodule

`default_nettype wire

// File: rtl/pulse_width_capture_buffer_unit.sv
// Edge interval capture buffer.
// Input channel (i_in_valid / o_in_stall) carries one beat per item: kind, timestamp,
// line level and read index. Output channel (o_out_valid / i_out_stall) returns
// exactly one result beat per input beat, in order.
// Configuration: i_cfg_we with i_cfg_index and i_cfg_data writes one register;
// write only while no item is in flight.
// A beat that is accepted waits in the front queue, and its result is registered
// in the output register of the back end. Throughput: one item per cycle while
// the receiver does not stall, set by the single state update and one sample
// memory access per cycle in the back end. A two-entry queue sits between the
// front decoder and the back end, and the result sits in an output register, so
// the input keeps flowing while the receiver stalls until the queue fills; then
// o_in_stall rises and stays high until the output is taken.
// Reset (synchronous, active low) clears the sample count, the reference time,
// the capture enable and the queue, and restores register defaults. The sample
// memory is not cleared; only entries below the count are ever returned.
`default_nettype none

module pulse_width_capture_buffer_unit
    import pwcb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [KIND_W-1:0]     i_kind,
    input  wire logic [TIME_W-1:0]     i_timestamp,
    input  wire logic                  i_line_level,
    input  wire logic [ADDR_W-1:0]     i_read_index,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_capture_done,
    output logic [CNT_W-1:0]           o_sample_count,
    output logic                       o_capturing,
    output logic [TIME_W-1:0]          o_read_value,
    output logic                       o_read_valid
);

    logic  w_q_valid;
    t_item w_q_item;
    logic  w_q_pop;

    // front: accept and classify
    pwcb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_timestamp  (i_timestamp),
        .i_line_level (i_line_level),
        .i_read_index (i_read_index),
        .o_q_valid    (w_q_valid),
        .o_q_item     (w_q_item),
        .i_q_pop      (w_q_pop)
    );

    // back: state, sample memory and result register
    pwcb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_q_item),
        .o_q_pop        (w_q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_capture_done (o_capture_done),
        .o_sample_count (o_sample_count),
        .o_capturing    (o_capturing),
        .o_read_value   (o_read_value),
        .o_read_valid   (o_read_valid)
    );

endmodule

`default_nettype wire

// File: rtl/pwcb_checker.sv
`default_nettype none

module pwcb_checker
    import pwcb_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic              o_capture_done,
    input wire logic [CNT_W-1:0]  o_sample_count,
    input wire logic              o_capturing,
    input wire logic [TIME_W-1:0] o_read_value,
    input wire logic              o_read_valid
);

    // a completed poll always leaves capture disabled
    a_done_disables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_capture_done |-> !o_capturing)
        else $error("capture done while still capturing");

    // a miss on read returns zero data
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_read_valid |-> o_read_value == '0)
        else $error("read data nonzero without a hit");

    // a read hit and a poll completion come from different kinds
    a_read_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_valid |-> !o_capture_done)
        else $error("read hit and capture done in one beat");

    // count never exceeds the buffer
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_sample_count <= CNT_W'(BUFFER_DEPTH))
        else $error("sample count beyond buffer depth");

    // stalled result beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_count))
        else $error("stalled result changed");

endmodule

bind pulse_width_capture_buffer_unit pwcb_checker u_pwcb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_capture_done (o_capture_done),
    .o_sample_count (o_sample_count),
    .o_capturing    (o_capturing),
    .o_read_value   (o_read_value),
    .o_read_valid   (o_read_valid)
);

`default_nettype wire

// File: test/pulse_width_capture_buffer_unit_tb.sv
`default_nettype none

module pulse_width_capture_buffer_unit_tb;
    import pwcb_pkg::*;

    localparam int     PERIOD       = 10;
    localparam longint RUN_LIMIT    = 64'd10_000_000;
    localparam int     RANDOM_ITEMS = 850;
    localparam int     PHASES       = 7;
    localparam int     FILL_EDGES   = BUFFER_DEPTH + 8;

    // one result beat as the block returns it
    typedef struct {
        logic              done;
        logic [CNT_W-1:0]  count;
        logic              capturing;
        logic [TIME_W-1:0] value;
        logic              valid;
    } capture_result_t;

    // interval capture predictor and in-order result checker
    class capture_checker;
        logic [TIME_W-1:0]  interval_mem [BUFFER_DEPTH];
        logic [CNT_W-1:0]   frame_count;
        logic [TIME_W-1:0]  ref_time;
        bit                 capture_on;
        bit                 fsk_on;
        logic [PULSE_W-1:0] pulse_floor;
        logic [TIME_W-1:0]  gap_ceiling;
        logic [CNT_W-1:0]   done_threshold;
        capture_result_t    pending_results [$];
        int                 errors;

        function new();
            frame_count    = '0;
            ref_time       = '0;
            capture_on     = 1'b0;
            fsk_on         = 1'b0;
            pulse_floor    = MIN_PULSE_RST;
            gap_ceiling    = GAP_LIMIT_RST;
            done_threshold = MIN_SAMPLES_RST;
            errors         = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FSK_MODE:    fsk_on = data[0];
                CFG_MIN_PULSE:   pulse_floor = data[PULSE_W-1:0];
                CFG_GAP_LIMIT:   gap_ceiling = data[TIME_W-1:0];
                CFG_MIN_SAMPLES: done_threshold = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // apply one accepted input beat and queue the result it must produce
        function void apply_item(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] ts, logic lvl,
                                 logic [ADDR_W-1:0] idx);
            capture_result_t   r;
            logic [TIME_W-1:0] span;
            r.done  = 1'b0;
            r.value = '0;
            r.valid = 1'b0;
            span    = ts - ref_time;
            case (kind)
                KIND_ARM: begin
                    frame_count = '0;
                    capture_on  = 1'b1;
                end
                KIND_EDGE: begin
                    if (capture_on) begin
                        // long idle restarts the frame, the gap itself may be sample zero
                        if (span > gap_ceiling)
                            frame_count = '0;
                        if (span >= TIME_W'(pulse_floor) && frame_count < BUFFER_DEPTH) begin
                            interval_mem[frame_count[ADDR_W-1:0]] = span;
                            frame_count = frame_count + 1'b1;
                        end
                        // full buffer: reference time frozen, no level check
                        if (frame_count < BUFFER_DEPTH) begin
                            if (fsk_on && frame_count == 1 && lvl != 1'b1)
                                frame_count = '0;
                            ref_time = ts;
                        end
                    end
                end
                KIND_POLL: begin
                    if (frame_count >= done_threshold && span > gap_ceiling) begin
                        capture_on = 1'b0;
                        r.done     = 1'b1;
                    end
                end
                KIND_READ: begin
                    if (CNT_W'(idx) < frame_count) begin
                        r.value = interval_mem[idx];
                        r.valid = 1'b1;
                    end
                end
                default: ;
            endcase
            r.count     = frame_count;
            r.capturing = capture_on;
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            if (errors < 100)
                $display("ERROR at %0t: %s", $time, what);
            errors++;
        endtask

        // compare one output beat with the oldest expectation
        task check_result(capture_result_t got);
            capture_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("result beat arrived with nothing expected");
                return;
            end
            want = pending_results.pop_front();
            if (got.done !== want.done)
                report_mismatch($sformatf("capture_done got %0d want %0d", got.done, want.done));
            if (got.count !== want.count)
                report_mismatch($sformatf("sample_count got %0d want %0d", got.count, want.count));
            if (got.capturing !== want.capturing)
                report_mismatch($sformatf("capturing got %0d want %0d",
                                          got.capturing, want.capturing));
            if (got.value !== want.value)
                report_mismatch($sformatf("read_value got %h want %h", got.value, want.value));
            if (got.valid !== want.valid)
                report_mismatch($sformatf("read_valid got %0d want %0d", got.valid, want.valid));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [KIND_W-1:0]     i_kind;
    logic [TIME_W-1:0]     i_timestamp;
    logic                  i_line_level;
    logic [ADDR_W-1:0]     i_read_index;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_capture_done;
    logic [CNT_W-1:0]      o_sample_count;
    logic                  o_capturing;
    logic [TIME_W-1:0]     o_read_value;
    logic                  o_read_valid;

    capture_checker sb = new();

    bit                tx_quiet;
    bit                rx_quiet;
    bit                quick;
    int                live_items;
    logic [TIME_W-1:0] now;

    pulse_width_capture_buffer_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_timestamp    (i_timestamp),
        .i_line_level   (i_line_level),
        .i_read_index   (i_read_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_capture_done (o_capture_done),
        .o_sample_count (o_sample_count),
        .o_capturing    (o_capturing),
        .o_read_value   (o_read_value),
        .o_read_valid   (o_read_valid)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(PERIOD / 2) i_clk = ~i_clk;
    end

    // hard stop if the run hangs
    initial begin
        #(RUN_LIMIT);
        $display("pulse_width_capture_buffer_unit: mismatch");
        $finish;
    end

    // interval for the next edge or poll, drawn around the current thresholds
    function automatic logic [TIME_W-1:0] pick_span(bit want_long);
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
        int                pick;
        lo   = TIME_W'(sb.pulse_floor);
        hi   = sb.gap_ceiling;
        pick = want_long ? 90 : $urandom_range(0, 99);
        if (pick < 75) begin
            if (hi < lo)
                return $urandom;
            if ($urandom_range(0, 1) == 0 && hi - lo > 3000)
                return lo + TIME_W'($urandom_range(0, 3000));
            return $urandom_range(lo, hi);
        end else if (pick < 88) begin
            return (lo == 0) ? '0 : TIME_W'($urandom_range(0, lo - 1));
        end else if (pick < 96) begin
            return (hi == '1) ? hi : TIME_W'($urandom_range(hi + 1, 32'hFFFF_FFFF));
        end
        return $urandom;
    endfunction

    // read index, mostly inside the current frame
    function automatic logic [ADDR_W-1:0] pick_index();
        if (sb.frame_count != 0 && $urandom_range(0, 3) != 0)
            return ADDR_W'($urandom_range(0, sb.frame_count - 1));
        return ADDR_W'($urandom);
    endfunction

    // one input beat; entered and left at a falling edge with valid still high
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] ts,
                             input logic lvl, input logic [ADDR_W-1:0] idx);
        int gap;
        gap = (quick || tx_quiet) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_timestamp  <= ts;
        i_line_level <= lvl;
        i_read_index <= idx;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        if (kind != KIND_EDGE || sb.capture_on)
            live_items++;
        sb.apply_item(kind, ts, lvl, idx);
        @(negedge i_clk);
    endtask

    // stop sending and wait for every expected beat
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // write all four registers, block idle
    task automatic set_config(input logic fsk, input logic [PULSE_W-1:0] pulse,
                              input logic [TIME_W-1:0] gap, input logic [CNT_W-1:0] need);
        logic [CFG_IDX_W-1:0]  regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{CFG_FSK_MODE, CFG_MIN_PULSE, CFG_GAP_LIMIT, CFG_MIN_SAMPLES};
        vals = '{CFG_DATA_W'(fsk), CFG_DATA_W'(pulse), CFG_DATA_W'(gap), CFG_DATA_W'(need)};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            sb.write_register(regs[i], vals[i]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // result side: random stall per beat, check at the accepting edge
    initial begin
        capture_result_t got;
        int              hold;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            hold = (quick || rx_quiet) ? 0 : $urandom_range(0, 19);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            got.done      = o_capture_done;
            got.count     = o_sample_count;
            got.capturing = o_capturing;
            got.value     = o_read_value;
            got.valid     = o_read_valid;
            sb.check_result(got);
        end
    end

    // stimulus
    initial begin
        logic [TIME_W-1:0] t;
        int                steps;
        int                pick;
        int                start;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_kind       = KIND_ARM;
        i_timestamp  = '0;
        i_line_level = 1'b0;
        i_read_index = '0;
        i_out_stall  = 1'b0;
        tx_quiet     = 1'b0;
        rx_quiet     = 1'b0;
        quick        = 1'b0;
        live_items   = 0;
        now          = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // nothing armed yet: edge ignored, poll and read see an empty frame
        send_item(KIND_EDGE, 32'hFFFF_FFFF, 1'b1, '0);
        send_item(KIND_POLL, 32'h0, 1'b0, '0);
        send_item(KIND_READ, 32'h0, 1'b0, '1);
        drain();
        set_config(1'b1, 16'd100, 32'd100000, 13'd3);

        // fsk frame: low first sample dropped, short pulse, wrap, exact thresholds
        send_item(KIND_ARM, 32'h0, 1'b0, '0);
        t = 32'hFFFF_FF00;
        send_item(KIND_EDGE, t, 1'b0, '0);
        t = t + 50;
        send_item(KIND_EDGE, t, 1'b1, '0);
        t = t + 300;
        send_item(KIND_EDGE, t, 1'b1, '0);
        t = t + 100;
        send_item(KIND_EDGE, t, 1'b0, '0);
        t = t + 100000;
        send_item(KIND_EDGE, t, 1'b1, '0);
        send_item(KIND_POLL, t + 100000, 1'b0, '0);
        send_item(KIND_READ, t, 1'b0, 12'd0);
        send_item(KIND_READ, t, 1'b0, 12'd2);
        send_item(KIND_READ, t, 1'b0, 12'd3);
        send_item(KIND_READ, t, 1'b0, 12'hFFF);
        send_item(KIND_POLL, t + 100001, 1'b0, '0);
        // done already, poll again while disabled, then an ignored edge
        send_item(KIND_POLL, t + 32'hFFFF_FFFF, 1'b1, '0);
        send_item(KIND_EDGE, t + 500, 1'b1, '0);
        // rearm: long gap becomes sample zero
        send_item(KIND_ARM, t, 1'b1, '0);
        t = t + 100001;
        send_item(KIND_EDGE, t, 1'b1, '0);
        send_item(KIND_READ, t, 1'b0, 12'd0);
        drain();

        // fill the buffer back to back, then hit it while full
        set_config(1'b0, 16'd1, 32'd1000, 13'd4096);
        quick = 1'b1;
        send_item(KIND_ARM, t, 1'b0, '0);
        repeat (FILL_EDGES) begin
            t = t + TIME_W'($urandom_range(1, 900));
            send_item(KIND_EDGE, t, 1'($urandom), '0);
        end
        send_item(KIND_READ, t, 1'b0, 12'hFFF);
        send_item(KIND_READ, t, 1'b0, 12'h000);
        repeat (4) send_item(KIND_READ, t, 1'b0, ADDR_W'($urandom));
        send_item(KIND_POLL, t + 1001, 1'b0, '0);
        send_item(KIND_ARM, t, 1'b0, '0);
        repeat (BUFFER_DEPTH) begin
            t = t + 5;
            send_item(KIND_EDGE, t, 1'b1, '0);
        end
        t = t + 5000;
        send_item(KIND_EDGE, t, 1'b1, '0);
        send_item(KIND_READ, t, 1'b0, 12'd0);
        send_item(KIND_READ, t, 1'b0, 12'd1);
        quick = 1'b0;
        now = t;
        drain();

        // random frames under several register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: set_config(1'b1, 16'd0, 32'hFFFF_FFFF, 13'd0);
                1: set_config(1'b0, 16'hFFFF, 32'd0, 13'd4096);
                2: set_config(1'b0, MIN_PULSE_RST, GAP_LIMIT_RST, MIN_SAMPLES_RST);
                default: set_config(1'($urandom), 16'($urandom_range(0, 3000)),
                                    32'($urandom_range(2000, 300000)),
                                    ($urandom_range(0, 2) == 0) ?
                                        13'($urandom_range(0, 4096)) :
                                        13'($urandom_range(0, 40)));
            endcase
            start = live_items;
            while (live_items - start < RANDOM_ITEMS / PHASES) begin
                tx_quiet = ($urandom_range(0, 4) == 0);
                rx_quiet = ($urandom_range(0, 4) == 0);
                // sender holds off until the block has answered everything
                if ($urandom_range(0, 9) == 0)
                    drain();
                if ($urandom_range(0, 9) != 0)
                    send_item(KIND_ARM, $urandom, 1'($urandom), ADDR_W'($urandom));
                if ($urandom_range(0, 7) == 0)
                    now = $urandom;
                steps = $urandom_range(0, 60);
                repeat (steps) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 78) begin
                        now = now + pick_span(1'b0);
                        send_item(KIND_EDGE, now, ($urandom_range(0, 3) != 0), ADDR_W'($urandom));
                    end else if (pick < 88) begin
                        send_item(KIND_READ, $urandom, 1'($urandom), pick_index());
                    end else if (pick < 94) begin
                        send_item(KIND_POLL, now + pick_span(1'($urandom)), 1'($urandom),
                                  ADDR_W'($urandom));
                    end else begin
                        send_item(KIND_W'($urandom), $urandom, 1'($urandom), pick_index());
                    end
                end
                // frame closes with an idle poll
                send_item(KIND_POLL, now + pick_span(1'b1), 1'b0, '0);
            end
        end

        drain();
        repeat (10) @(negedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch("expected result beats never arrived");
        if (sb.errors == 0)
            $display("pulse_width_capture_buffer_unit: match");
        else
            $display("pulse_width_capture_buffer_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
